FILE: design/mbt_pkg.sv
// Package for the Manchester burst transmitter.
// Holds frame constants, opcode and register codes, shared types and the checksum function.
// No dependencies.
package mbt_pkg;

    localparam int BURSTS      = 2;
    localparam int FRAME_BITS  = 53;
    localparam int DATA_SLOTS  = 2 * (FRAME_BITS - 1);
    localparam int SLOT_W      = 12;
    localparam int BURST_W     = (BURSTS > 1) ? $clog2(BURSTS) : 1;
    localparam int IDX_W       = $clog2(DATA_SLOTS);
    localparam int POS_W       = $clog2(FRAME_BITS);
    localparam int DUR_W       = 16;
    localparam int RPT_W       = 8;
    localparam int HDR_W       = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CHK_NIBBLES = 12;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_NEXT = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENDLESS = 3'd4;

    localparam logic [DUR_W-1:0] RST_SHORT  = 16'd500;
    localparam logic [DUR_W-1:0] RST_LONG   = 16'd1000;
    localparam logic [RPT_W-1:0] RST_REPEAT = 8'd10;
    localparam logic [HDR_W-1:0] RST_HEADER = 10'd252;

    typedef logic [FRAME_BITS-1:0] t_key;

    typedef struct packed {
        logic [DUR_W-1:0] short_us;
        logic [DUR_W-1:0] long_us;
        logic [RPT_W-1:0] repeat_count;
        logic [HDR_W-1:0] header_pairs;
        logic             endless;
    } t_cfg;

    typedef struct packed {
        logic             active;
        logic             level;
        logic [DUR_W-1:0] duration_us;
        logic             round_end;
        t_key             key_with_check;
    } t_result;

    function automatic logic [3:0] check_nibble(input t_key key);
        logic [63:0] wide;
        logic [3:0]  acc;
        wide = 64'(key);
        acc  = 4'h0;
        for (int n = 0; n < CHK_NIBBLES; n++) begin
            acc = acc ^ wide[4 + 4*n +: 4];
        end
        return acc + 4'd1;
    endfunction

endpackage

FILE: design/mbt_pulse_gen.sv
// Pulse generator: key store, burst/slot counters, repeat count and the per-transaction result.
// Depends on mbt_pkg.
module mbt_pulse_gen
    import mbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_opcode,
    input  t_key       i_frame_key,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_key               r_key;
    logic [BURST_W-1:0] r_burst;
    logic [SLOT_W-1:0]  r_slot;
    logic [RPT_W-1:0]   r_repeats;
    logic               r_running;

    t_key               n_key;
    logic [BURST_W-1:0] n_burst;
    logic [SLOT_W-1:0]  n_slot;
    logic [RPT_W-1:0]   n_repeats;
    logic               n_running;

    logic [SLOT_W-1:0]  pre;
    logic [SLOT_W-1:0]  len;
    logic [SLOT_W-1:0]  diff;
    logic [IDX_W-1:0]   idx;
    logic [POS_W-1:0]   pos;
    logic               key_bit;
    logic [BURST_W:0]   burst_inc;
    logic               last_slot;

    always_comb begin
        pre  = SLOT_W'({i_cfg.header_pairs, 1'b0});
        len  = pre + SLOT_W'(DATA_SLOTS + 1);
        diff = r_slot - pre - SLOT_W'(1);
        if (diff >= SLOT_W'(DATA_SLOTS)) begin
            idx = IDX_W'(DATA_SLOTS - 1);
        end else begin
            idx = diff[IDX_W-1:0];
        end
        pos       = POS_W'(FRAME_BITS - 2) - POS_W'(idx >> 1);
        key_bit   = r_key[pos];
        burst_inc = {1'b0, r_burst} + (BURST_W+1)'(1);
        last_slot = (r_slot + SLOT_W'(1)) >= len;
    end

    always_comb begin
        n_key     = r_key;
        n_burst   = r_burst;
        n_slot    = r_slot;
        n_repeats = r_repeats;
        n_running = r_running;
        o_result  = '0;
        case (i_opcode)
            OP_LOAD: begin
                n_key     = {i_frame_key[FRAME_BITS-1:4], check_nibble(i_frame_key)};
                n_burst   = '0;
                n_slot    = '0;
                n_repeats = i_cfg.repeat_count;
                n_running = 1'b1;
            end
            OP_STOP: begin
                n_running = 1'b0;
            end
            OP_NEXT: begin
                if (r_repeats == '0 || !r_running) begin
                    n_running = 1'b0;
                end else begin
                    o_result.active = 1'b1;
                    if (r_slot < pre) begin
                        o_result.level       = r_slot[0];
                        o_result.duration_us = i_cfg.long_us;
                    end else if (r_slot == pre) begin
                        o_result.level       = 1'b0;
                        o_result.duration_us = i_cfg.short_us;
                    end else begin
                        o_result.level       = key_bit ^ idx[0];
                        o_result.duration_us = i_cfg.short_us;
                    end
                    if (last_slot) begin
                        n_slot = '0;
                        if (burst_inc >= (BURST_W+1)'(BURSTS)) begin
                            n_burst            = '0;
                            o_result.round_end = 1'b1;
                            if (!i_cfg.endless) begin
                                n_repeats = r_repeats - RPT_W'(1);
                            end
                        end else begin
                            n_burst = burst_inc[BURST_W-1:0];
                        end
                    end else begin
                        n_slot = r_slot + SLOT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        o_result.key_with_check = n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_burst   <= '0;
            r_slot    <= '0;
            r_repeats <= '0;
            r_running <= 1'b0;
        end else if (i_accept) begin
            r_key     <= n_key;
            r_burst   <= n_burst;
            r_slot    <= n_slot;
            r_repeats <= n_repeats;
            r_running <= n_running;
        end
    end

endmodule

FILE: design/mbt_out_skid.sv
// Two-entry output buffer: result register plus skid register for the result channel.
// Depends on mbt_pkg.
module mbt_out_skid
    import mbt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_full
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    logic    n_main_valid;
    logic    n_skid_valid;
    t_result n_main;
    t_result n_skid;
    logic    take;

    always_comb begin
        take         = r_main_valid && !i_stall;
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (take) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_main = i_data;
            end else begin
                n_main_valid = 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end else begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign o_full  = r_skid_valid;

endmodule

FILE: design/manchester_burst_transmitter.sv
// Top level of the Manchester burst transmitter: configuration registers, pulse generator
// and output buffer. Depends on mbt_pkg, mbt_pulse_gen and mbt_out_skid.
//
// Usage: the input channel (i_in_valid / o_in_stall) carries one transaction per item:
// load a key and start, request the next pulse, or stop. Every input transaction yields
// exactly one result transaction on the output channel (o_out_valid / i_out_stall):
// active flag, line level, pulse duration, round-end flag and the stored key with its
// checksum nibble. Pulses are generated from the burst and slot counters, not a buffer.
// Each result is registered in the output buffer; one transaction per cycle is accepted
// while o_in_stall is low. Configuration must be written by the user through i_cfg_we /
// i_cfg_idx / i_cfg_data only while idle; the block itself does not enforce this.
// Synchronous active-low reset restores the default register values, clears the key,
// counters and running flag, and empties the output buffer.
// When the receiver stalls, the result register holds and one more result lands in the
// skid register; o_in_stall rises only while that skid register is occupied.
module manchester_burst_transmitter
    import mbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_opcode,
    input  logic [FRAME_BITS-1:0] i_frame_key,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_active,
    output logic                  o_level,
    output logic [DUR_W-1:0]      o_duration_us,
    output logic                  o_round_end,
    output logic [FRAME_BITS-1:0] o_key_with_check,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_result gen_result;
    t_result out_result;
    logic    in_accept;
    logic    skid_full;

    assign o_in_stall = skid_full;
    assign in_accept  = i_in_valid && !skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_us     <= RST_SHORT;
            r_cfg.long_us      <= RST_LONG;
            r_cfg.repeat_count <= RST_REPEAT;
            r_cfg.header_pairs <= RST_HEADER;
            r_cfg.endless      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHORT:   r_cfg.short_us     <= i_cfg_data;
                CFG_LONG:    r_cfg.long_us      <= i_cfg_data;
                CFG_REPEAT:  r_cfg.repeat_count <= i_cfg_data[RPT_W-1:0];
                CFG_HEADER:  r_cfg.header_pairs <= i_cfg_data[HDR_W-1:0];
                CFG_ENDLESS: r_cfg.endless      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    mbt_pulse_gen u_pulse_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_opcode    (i_opcode),
        .i_frame_key (i_frame_key),
        .i_cfg       (r_cfg),
        .o_result    (gen_result)
    );

    mbt_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (gen_result),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_result),
        .o_full  (skid_full)
    );

    assign o_active         = out_result.active;
    assign o_level          = out_result.level;
    assign o_duration_us    = out_result.duration_us;
    assign o_round_end      = out_result.round_end;
    assign o_key_with_check = out_result.key_with_check;

endmodule
